### sv/plug_gated_packet_fifo_unit_assert.svh
// assertion macros for the plug gated packet fifo
// no dependencies; expects clk and rst_n in the including module
`ifndef PLUG_GATED_PACKET_FIFO_UNIT_ASSERT_SVH
`define PLUG_GATED_PACKET_FIFO_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PGPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgpf assertion failed");
// next-cycle implication
`define PGPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgpf assertion failed");
`else
`define PGPF_ASSERT_NOW(lbl, ante, cons)
`define PGPF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/pgpf_pkg.sv
// shared types and constants for the plug gated packet fifo
// no dependencies
package pgpf_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int LIMIT_W         = 24;
    localparam int LEN_W           = 16;
    localparam int TAG_W           = 32;
    localparam int QCNT_W          = 7;
    localparam int DATA_W          = TAG_W + LEN_W;

    localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RESET = LIMIT_W'(10 * 1024 * 1024);

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_PLUG   = 2'd2,
        CMD_UNPLUG = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        STS_DONE       = 3'd0,
        STS_OVER_LIMIT = 3'd1,
        STS_NO_SLOT    = 3'd2,
        STS_BLOCKED    = 3'd3,
        STS_EMPTY      = 3'd4
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        cmd_code_t          cmd;
        logic [LEN_W-1:0]   pkt_len;
        logic [TAG_W-1:0]   pkt_tag;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               out_valid;
        logic [LEN_W-1:0]   out_len;
        logic [TAG_W-1:0]   out_tag;
        logic [LIMIT_W-1:0] backlog_now;
        logic [QCNT_W-1:0]  queued_now;
    } rsp_t;

endpackage

### sv/pgpf_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module pgpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/plug_gated_packet_fifo_unit.sv
// plug gated packet descriptor fifo, top level
// depends on pgpf_pkg, pgpf_ram and plug_gated_packet_fifo_unit_assert.svh
//
//  channel   signals                       direction  handshake
//  command   start, busy, req              in         taken when start & !busy
//  result    done, rsp                     out        one-cycle strobe on done
//  config    cfg_valid, cfg_ready, cfg_data in        written when valid & ready
//
// a command passes through ST_EXEC: the accept edge launches the read of the head slot
// in the descriptor ram, the next edge commits the update and registers the word.
// done is high for the cycle after that, when busy is already low again, so no new
// command is taken before the previous one commits. the receiver cannot stall.
// reset leaves the queue empty, throttled, unmarked, with the byte limit at 10 MiB.
module plug_gated_packet_fifo_unit
    import pgpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    output logic               done,
    output rsp_t               rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    `include "plug_gated_packet_fifo_unit_assert.svh"

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    ctrl_state_t        state_reg, state_next;
    req_t               cmd_reg;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] backlog_reg, backlog_next;
    logic [SLOT_W-1:0]  stop_slot_reg, stop_slot_next;
    logic               stop_valid_reg, stop_valid_next;
    logic               throttled_reg, throttled_next;
    logic [LIMIT_W-1:0] limit_reg;
    rsp_t               rsp_reg, rsp_next;
    logic               done_reg, done_next;

    logic               ram_we;
    logic [DATA_W-1:0]  ram_rdata;
    logic [LEN_W-1:0]   head_len;
    logic [TAG_W-1:0]   head_tag;
    logic [LIMIT_W:0]   enq_sum;

    pgpf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_desc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({cmd_reg.pkt_tag, cmd_reg.pkt_len}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign head_len = ram_rdata[LEN_W-1:0];
    assign head_tag = ram_rdata[DATA_W-1:LEN_W];
    assign enq_sum  = {1'b0, backlog_reg} + (LIMIT_W+1)'(cmd_reg.pkt_len);

    assign busy      = (state_reg == ST_EXEC);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            backlog_reg    <= '0;
            stop_slot_reg  <= '0;
            stop_valid_reg <= 1'b0;
            throttled_reg  <= 1'b1;
            limit_reg      <= BYTE_LIMIT_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            backlog_reg    <= backlog_next;
            stop_slot_reg  <= stop_slot_next;
            stop_valid_reg <= stop_valid_next;
            throttled_reg  <= throttled_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        backlog_next    = backlog_reg;
        stop_slot_next  = stop_slot_reg;
        stop_valid_next = stop_valid_reg;
        throttled_next  = throttled_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;
        ram_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next         = ST_IDLE;
                done_next          = 1'b1;
                rsp_next.status    = STS_DONE;
                rsp_next.out_valid = 1'b0;
                rsp_next.out_len   = '0;
                rsp_next.out_tag   = '0;

                unique case (cmd_reg.cmd)
                    CMD_ENQ:
                    begin
                        if (enq_sum > {1'b0, limit_reg})
                        begin
                            rsp_next.status = STS_OVER_LIMIT;
                        end
                        else if (count_reg >= FULL_CNT)
                        begin
                            rsp_next.status = STS_NO_SLOT;
                        end
                        else
                        begin
                            // first accepted packet after a plug becomes the mark
                            if (!stop_valid_reg)
                            begin
                                stop_slot_next  = tail_reg;
                                stop_valid_next = 1'b1;
                            end
                            ram_we       = 1'b1;
                            tail_next    = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                            count_next   = count_reg + 1'b1;
                            backlog_next = enq_sum[LIMIT_W-1:0];
                        end
                    end
                    CMD_DEQ:
                    begin
                        if (throttled_reg)
                        begin
                            rsp_next.status = STS_BLOCKED;
                        end
                        else if (count_reg == '0)
                        begin
                            rsp_next.status = STS_EMPTY;
                        end
                        else if (stop_valid_reg && (head_reg == stop_slot_reg))
                        begin
                            throttled_next  = 1'b1;
                            rsp_next.status = STS_BLOCKED;
                        end
                        else
                        begin
                            rsp_next.out_valid = 1'b1;
                            rsp_next.out_len   = head_len;
                            rsp_next.out_tag   = head_tag;
                            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            backlog_next = (backlog_reg >= LIMIT_W'(head_len))
                                         ? backlog_reg - LIMIT_W'(head_len) : '0;
                        end
                    end
                    CMD_PLUG:
                    begin
                        stop_valid_next = 1'b0;
                    end
                    CMD_UNPLUG:
                    begin
                        throttled_next = 1'b0;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase

                rsp_next.backlog_now = backlog_next;
                // the count field is seven bits wide; deeper queues wrap it
                rsp_next.queued_now  = QCNT_W'(count_next);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PGPF_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT)
    `PGPF_ASSERT_NOW(a_empty_no_bytes, count_reg == '0, backlog_reg == '0)
    `PGPF_ASSERT_NEXT(a_exec_gives_done, busy, done && !busy)
    `PGPF_ASSERT_NOW(a_release_is_done, done && rsp.out_valid, rsp.status == STS_DONE)
    `PGPF_ASSERT_NEXT(a_mark_blocks, busy && cmd_reg.cmd == CMD_DEQ && !throttled_reg
        && count_reg != '0 && stop_valid_reg && head_reg == stop_slot_reg,
        throttled_reg && !rsp.out_valid)

endmodule

### bench/plug_gated_packet_fifo_unit_tb.sv
// self-checking testbench for plug_gated_packet_fifo_unit: directed and random command streams
// checked word by word against a behavioural mirror of the queue, plug and throttle state
// depends on pgpf_pkg and the plug_gated_packet_fifo_unit rtl
module plug_gated_packet_fifo_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pgpf_pkg::*;

    localparam int          DEPTH          = QUEUE_DEPTH_DEF;
    localparam int          CLK_PERIOD     = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;

    class fifo_mirror;
        logic [LIMIT_W-1:0] byte_limit;
        logic [TAG_W-1:0]   tag_mem [DEPTH];
        logic [LEN_W-1:0]   len_mem [DEPTH];
        int unsigned        head_slot;
        int unsigned        tail_slot;
        int unsigned        queued;
        int unsigned        backlog;
        int unsigned        mark_slot;
        bit                 mark_valid;
        bit                 throttled;
        rsp_t               expected_words[$];
        int unsigned        mismatches;

        function new();
            byte_limit = BYTE_LIMIT_RESET;
            head_slot  = 0;
            tail_slot  = 0;
            queued     = 0;
            backlog    = 0;
            mark_slot  = 0;
            mark_valid = 1'b0;
            throttled  = 1'b1;
            mismatches = 0;
        endfunction

        function int unsigned next_slot(int unsigned s);
            return (s + 1 >= DEPTH) ? 0 : s + 1;
        endfunction

        function void note_command(req_t r);
            rsp_t w;
            w        = '0;
            w.status = STS_DONE;
            case (r.cmd)
                CMD_ENQ:
                begin
                    // limit takes precedence over a full queue
                    if (backlog + r.pkt_len > byte_limit)
                        w.status = STS_OVER_LIMIT;
                    else if (queued >= DEPTH)
                        w.status = STS_NO_SLOT;
                    else
                    begin
                        if (!mark_valid)
                        begin
                            mark_slot  = tail_slot;
                            mark_valid = 1'b1;
                        end
                        tag_mem[tail_slot] = r.pkt_tag;
                        len_mem[tail_slot] = r.pkt_len;
                        tail_slot = next_slot(tail_slot);
                        queued++;
                        backlog = (backlog + r.pkt_len) & 32'h00FF_FFFF;
                    end
                end
                CMD_DEQ:
                begin
                    if (throttled)
                        w.status = STS_BLOCKED;
                    else if (queued == 0)
                        w.status = STS_EMPTY;
                    else if (mark_valid && head_slot == mark_slot)
                    begin
                        throttled = 1'b1;
                        w.status  = STS_BLOCKED;
                    end
                    else
                    begin
                        w.out_valid = 1'b1;
                        w.out_len   = len_mem[head_slot];
                        w.out_tag   = tag_mem[head_slot];
                        head_slot   = next_slot(head_slot);
                        queued--;
                        backlog = (backlog >= w.out_len) ? backlog - w.out_len : 0;
                    end
                end
                CMD_PLUG:
                    mark_valid = 1'b0;
                default:
                    throttled = 1'b0;
            endcase
            w.backlog_now = LIMIT_W'(backlog);
            w.queued_now  = QCNT_W'(queued);
            expected_words.push_back(w);
        endfunction

        function void check_word(rsp_t got);
            rsp_t want;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: %h", got);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.out_valid !== want.out_valid)
            begin
                $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
                mismatches++;
            end
            if (got.out_len !== want.out_len)
            begin
                $error("out_len: expected %0d, got %0d", want.out_len, got.out_len);
                mismatches++;
            end
            if (got.out_tag !== want.out_tag)
            begin
                $error("out_tag: expected %h, got %h", want.out_tag, got.out_tag);
                mismatches++;
            end
            if (got.backlog_now !== want.backlog_now)
            begin
                $error("backlog_now: expected %0d, got %0d", want.backlog_now, got.backlog_now);
                mismatches++;
            end
            if (got.queued_now !== want.queued_now)
            begin
                $error("queued_now: expected %0d, got %0d", want.queued_now, got.queued_now);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    req_t               req       = '0;
    logic               done;
    rsp_t               rsp;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;

    fifo_mirror  mirror      = new();
    int unsigned idle_cycles = 0;
    int unsigned len_cap     = 65535;
    bit          calm        = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    plug_gated_packet_fifo_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // everything is sampled at the edge, before this step's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                mirror.note_command(req);
            if (done)
                mirror.check_word(rsp);
            if (cfg_valid && cfg_ready)
                mirror.byte_limit = cfg_data;
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return LEN_W'(len_cap);
        return LEN_W'($urandom_range(0, len_cap));
    endfunction

    task automatic issue(input req_t r, input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic send(input cmd_code_t c, input logic [LEN_W-1:0] len,
                        input logic [TAG_W-1:0] tag);
        req_t r;
        r.cmd     = c;
        r.pkt_len = len;
        r.pkt_tag = tag;
        issue(r, pick_gap());
    endtask

    // ignored fields still carry random values
    task automatic send_rand(input cmd_code_t c);
        send(c, pick_len(), $urandom);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (mirror.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly plug / fill / unplug / drain episodes, with some loose commands between
    task automatic run_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned k;
        int unsigned extra;
        cmd_code_t   c;
        sent = 0;
        while (sent < n_items)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                k     = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70)
                                                    : $urandom_range(1, 8);
                extra = $urandom_range(0, 3);
                if ($urandom_range(0, 3) != 0)
                    send_rand(CMD_PLUG);
                repeat (k) send_rand(CMD_ENQ);
                send_rand(CMD_UNPLUG);
                repeat (k + extra) send_rand(CMD_DEQ);
                sent += 2 * k + extra + 2;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                begin
                    c = cmd_code_t'($urandom_range(0, 3));
                    send_rand(c);
                end
                sent += k;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b0;
        send_rand(CMD_DEQ);                         // throttled straight after reset
        send_rand(CMD_UNPLUG);
        send_rand(CMD_DEQ);                         // empty queue
        send(CMD_ENQ, '0, '0);                      // zero length, becomes the mark
        send(CMD_ENQ, '1, '1);
        send_rand(CMD_ENQ);
        send_rand(CMD_DEQ);                         // head at mark, throttles
        send_rand(CMD_DEQ);
        send_rand(CMD_UNPLUG);
        send_rand(CMD_DEQ);                         // mark still there
        send_rand(CMD_PLUG);
        send_rand(CMD_UNPLUG);
        send_rand(CMD_DEQ);
        send_rand(CMD_DEQ);
        send_rand(CMD_PLUG);
        send_rand(CMD_ENQ);                         // new mark behind the old packet
        send_rand(CMD_DEQ);
        send_rand(CMD_DEQ);
        write_limit('0);
        send(CMD_ENQ, 16'd1, $urandom);             // over the limit
        send(CMD_ENQ, '0, $urandom);

        len_cap = 3;
        run_phase(60);
        write_limit('1);
        len_cap = 65535;
        run_phase(130);
        write_limit(LIMIT_W'(300));
        len_cap = 40;
        run_phase(130);
        write_limit(LIMIT_W'(600000));
        len_cap = 65535;
        run_phase(130);
        write_limit(LIMIT_W'($urandom_range(1000, 3000000)));
        run_phase(130);
        write_limit(BYTE_LIMIT_RESET);
        run_phase(130);

        drain();
        if (mirror.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
